FILE: hdl/tnf_pkg.sv
package tnf_pkg;

  localparam int ByteW = 8;

  typedef logic [ByteW-1:0] byte_t;

  // telnet command codes
  localparam byte_t TN_IAC  = 8'd255;
  localparam byte_t TN_DONT = 8'd254;
  localparam byte_t TN_DO   = 8'd253;
  localparam byte_t TN_WONT = 8'd252;
  localparam byte_t TN_WILL = 8'd251;

  localparam byte_t CH_LF = 8'd10;
  localparam byte_t CH_CR = 8'd13;

  // where a result goes
  localparam logic DEST_APP  = 1'b0;
  localparam logic DEST_PEER = 1'b1;

  typedef enum logic [6:0] {
    ST_NORMAL = 7'b0000001,
    ST_IAC    = 7'b0000010,
    ST_WILL   = 7'b0000100,
    ST_WONT   = 7'b0001000,
    ST_DO     = 7'b0010000,
    ST_DONT   = 7'b0100000,
    ST_CR     = 7'b1000000
  } tnf_state_t;

  // up to three result bytes caused by one received byte, all to one destination
  typedef struct packed {
    logic [1:0] count;
    logic       dest;
    byte_t      b0;
    byte_t      b1;
    byte_t      b2;
  } burst_t;

endpackage

FILE: hdl/tnf_parser.sv
module tnf_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  tnf_pkg::byte_t  rx_byte,
  output tnf_pkg::burst_t burst
);
  import tnf_pkg::*;

  tnf_state_t state;
  tnf_state_t state_next;

  always_comb begin
    burst      = '0;
    state_next = state;
    unique case (state) inside
      ST_IAC: begin
        state_next = ST_NORMAL;
        case (rx_byte)
          TN_WILL: state_next = ST_WILL;
          TN_WONT: state_next = ST_WONT;
          TN_DO:   state_next = ST_DO;
          TN_DONT: state_next = ST_DONT;
          TN_IAC: begin
            // escaped 255 is data
            burst.count = 2'd1;
            burst.dest  = DEST_APP;
            burst.b0    = TN_IAC;
          end
          default: ;
        endcase
      end
      ST_WILL: begin
        burst.count = 2'd3;
        burst.dest  = DEST_PEER;
        burst.b0    = TN_IAC;
        burst.b1    = TN_DONT;
        burst.b2    = rx_byte;
        state_next  = ST_NORMAL;
      end
      ST_DO: begin
        burst.count = 2'd3;
        burst.dest  = DEST_PEER;
        burst.b0    = TN_IAC;
        burst.b1    = TN_WONT;
        burst.b2    = rx_byte;
        state_next  = ST_NORMAL;
      end
      ST_WONT, ST_DONT: begin
        state_next = ST_NORMAL;
      end
      ST_CR: begin
        // byte after cr goes through unparsed, a following lf is swallowed
        burst.dest  = DEST_APP;
        burst.b0    = CH_LF;
        burst.b1    = rx_byte;
        burst.count = (rx_byte == CH_LF) ? 2'd1 : 2'd2;
        state_next  = ST_NORMAL;
      end
      default: begin
        if (rx_byte == TN_IAC) begin
          state_next = ST_IAC;
        end else if (rx_byte == CH_CR) begin
          state_next = ST_CR;
        end else begin
          burst.count = 2'd1;
          burst.dest  = DEST_APP;
          burst.b0    = rx_byte;
          state_next  = ST_NORMAL;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_NORMAL;
    end else if (accept) begin
      state <= state_next;
    end
  end

  a_reply_full: assert property (@(posedge clk) disable iff (rst)
    (burst.dest == DEST_PEER) |-> (burst.count == 2'd3))
    else $error("peer reply not three bytes");

  a_option_done: assert property (@(posedge clk) disable iff (rst)
    (accept && (state == ST_WILL || state == ST_DO || state == ST_WONT ||
                state == ST_DONT)) |=> (state == ST_NORMAL))
    else $error("parser stuck after option byte");

endmodule

FILE: hdl/tnf_burst.sv
module tnf_burst (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tnf_pkg::burst_t burst,
  output logic            m_tvalid,
  input  logic            m_tready,
  output tnf_pkg::byte_t  m_tdata,
  output logic            m_tuser,
  output logic            m_tlast
);
  import tnf_pkg::*;

  logic [1:0] cnt;
  logic       dest;
  byte_t      b0;
  byte_t      b1;
  byte_t      b2;
  logic       take;
  logic       load;

  assign take     = m_tvalid && m_tready;
  // free when empty or the final beat leaves this cycle
  assign in_ready = (cnt == 2'd0) || ((cnt == 2'd1) && m_tready);
  assign load     = in_valid && in_ready;

  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = b0;
  assign m_tuser  = dest;
  assign m_tlast  = (cnt == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= burst.count;
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dest <= burst.dest;
      b0   <= burst.b0;
      b1   <= burst.b1;
      b2   <= burst.b2;
    end else if (take) begin
      b0 <= b1;
      b1 <= b2;
    end
  end

  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    (cnt > 2'd1) |-> !in_ready)
    else $error("input taken while burst pending");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (take && cnt == 2'd2) |=> (cnt == 2'd1))
    else $error("burst count slipped");

  a_shift: assert property (@(posedge clk) disable iff (rst)
    (take && cnt > 2'd1) |=> (m_tdata == $past(b1) && m_tuser == $past(dest)))
    else $error("burst beat order broken");

endmodule

FILE: hdl/telnet_option_refusal_filter.sv
// a result beat appears on the master side in the cycle after its byte is taken
// throughput: one byte per cycle while no byte gives over one beat and m_tready is high
// an option reply holds the output register for three beats, a cr not followed by lf for two,
// and the slave side waits until the final beat of that burst is taken
// reset: synchronous, clears the parser to normal data and drops any pending beats
module telnet_option_refusal_filter (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] rx_byte
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,   // [7:0] out_byte
  output logic                m_tuser,   // [0] destination
  output logic                m_tlast
);
  import tnf_pkg::*;

  burst_t burst;
  logic   accept;

  assign accept = s_tvalid && s_tready;

  tnf_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (s_tdata),
    .burst   (burst)
  );

  tnf_burst u_burst (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .burst    (burst),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
